[hdl/spm_pkg.sv]
// ---------------------------------------------------------------------------
// spm_pkg
// shared constants, types and helpers for the sparse paged memory
// ---------------------------------------------------------------------------
package spm_pkg;

    localparam int PAGE_OFFSET_BITS_DEF = 12;
    localparam int FRAME_COUNT_DEF      = 16;

    localparam int ADDR_W   = 64;
    localparam int DATA_W   = 64;
    localparam int SIZE_W   = 2;
    localparam int LANE_W   = 3;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // register index, taken from paddr[2]
    localparam logic CFG_IDX_LITTLE_ENDIAN = 1'b0;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK_RD,
        ST_LOOK_CMP,
        ST_XFER,
        ST_DRAIN,
        ST_DONE
    } spm_state_t;

    // index of the last byte of an access
    function automatic logic [LANE_W-1:0] last_byte_idx(input logic [SIZE_W-1:0] size_code);
        logic [LANE_W-1:0] res;
        case (size_code)
            2'd0:    res = 3'd0;
            2'd1:    res = 3'd1;
            2'd2:    res = 3'd3;
            default: res = 3'd7;
        endcase
        return res;
    endfunction

endpackage

[hdl/sparse_paged_memory.sv]
// ---------------------------------------------------------------------------
// sparse_paged_memory
// sparse byte memory over a 64-bit address space, pages mapped on first write
// ---------------------------------------------------------------------------
// usage:
//   s_ channel takes one access request: s_action (0 read, 1 write), s_address,
//   s_size_code (log2 bytes) and s_write_data. m_ channel returns one result per
//   request: m_read_data (zero for writes) and m_status (1 when a write found no
//   free page frame). user sets little_endian via apb port while idle, unchecked.
// timing:
//   each page lookup takes, per tag compared, one tag memory read and one pass
//   through the single compare unit, and one more tag memory read when the page
//   is not found; with k frames in use up to k tags are compared. each byte then
//   passes through the single-port frame memory, a drain and a done state follow,
//   and m_valid rises when the result leaves the done state; a page crossing
//   access does two lookups, a write with no free frame stops at that page.
//   s_ready is high only in the idle state between requests.
// reset:
//   aresetn clears the frame count and the config register, then the block runs
//   a clearing pass over the FRAME_COUNT << PAGE_OFFSET_BITS bytes of the frame
//   memory (65536 by default) with s_ready low; apb writes are taken meanwhile.
// stall:
//   the result sits in an output register; a new request is taken and worked
//   on while m_ready is low, and the block waits to hand over its next result.
// ---------------------------------------------------------------------------
module sparse_paged_memory
    import spm_pkg::*;
#(
    parameter int PAGE_OFFSET_BITS = PAGE_OFFSET_BITS_DEF,
    parameter int FRAME_COUNT      = FRAME_COUNT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,

    // request channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    input  logic [ADDR_W-1:0]   s_address,
    input  logic [SIZE_W-1:0]   s_size_code,
    input  logic [DATA_W-1:0]   s_write_data,

    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [DATA_W-1:0]   m_read_data,
    output logic                m_status,

    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int TAG_W     = ADDR_W - PAGE_OFFSET_BITS;
    localparam int FRAME_W   = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int CNT_W     = $clog2(FRAME_COUNT + 1);
    localparam int MEM_AW    = FRAME_W + PAGE_OFFSET_BITS;
    localparam int MEM_DEPTH = FRAME_COUNT << PAGE_OFFSET_BITS;

    // state and datapath registers
    spm_state_t             state_reg, state_next;
    logic                   act_reg, act_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic [LANE_W-1:0]      last_reg, last_next;
    logic [DATA_W-1:0]      wdata_reg, wdata_next;
    logic [LANE_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]       scan_reg, scan_next;
    logic                   hit_reg, hit_next;
    logic [FRAME_W-1:0]     frame_reg, frame_next;
    logic [DATA_W-1:0]      rdata_reg, rdata_next;
    logic                   status_reg, status_next;
    logic                   pend_reg, pend_next;
    logic [LANE_W-1:0]      pend_lane_reg, pend_lane_next;
    logic [CNT_W-1:0]       used_reg, used_next;
    logic [MEM_AW-1:0]      clr_reg, clr_next;
    logic                   le_reg, le_next;
    logic                   m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]      m_data_reg, m_data_next;
    logic                   m_status_reg, m_status_next;

    // memories
    logic [TAG_W-1:0]       tag_mem [FRAME_COUNT];
    logic [TAG_W-1:0]       tag_q_reg;
    logic [7:0]             frame_mem [MEM_DEPTH];
    logic [7:0]             mem_q_reg;

    // control from the sequencer
    logic                   tag_we;
    logic                   mem_we;
    logic [7:0]             mem_wdata;
    logic [MEM_AW-1:0]      mem_addr;

    // helpers
    logic [TAG_W-1:0]       cur_tag;
    logic [ADDR_W-1:0]      addr_inc;
    logic [LANE_W-1:0]      lane;
    logic                   accept;
    logic                   miss;
    logic                   full;
    logic                   tag_match;
    logic                   out_free;
    logic                   cfg_we;

    assign cur_tag   = addr_reg[ADDR_W-1:PAGE_OFFSET_BITS];
    assign addr_inc  = addr_reg + ADDR_W'(1);
    // byte lane of the current byte inside the packed value
    assign lane      = le_reg ? idx_reg : (last_reg - idx_reg);
    assign accept    = s_valid && s_ready;
    assign miss      = (scan_reg == used_reg);
    assign full      = (used_reg == CNT_W'(FRAME_COUNT));
    assign tag_match = (tag_q_reg == cur_tag);
    assign out_free  = !m_valid_reg || m_ready;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_LITTLE_ENDIAN);
    assign prdata = (paddr[2] == CFG_IDX_LITTLE_ENDIAN) ? {{(APB_DW-1){1'b0}}, le_reg}
                                                        : '0;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == MEM_AW'(MEM_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOOK_RD;
                end
            end
            ST_LOOK_RD: begin
                if (!miss) begin
                    state_next = ST_LOOK_CMP;
                end else if (act_reg == ACT_WRITE && full) begin
                    state_next = ST_DRAIN;
                end else begin
                    state_next = ST_XFER;
                end
            end
            ST_LOOK_CMP: begin
                state_next = tag_match ? ST_XFER : ST_LOOK_RD;
            end
            ST_XFER: begin
                if (idx_reg == last_reg) begin
                    state_next = ST_DRAIN;
                end else if (addr_inc[PAGE_OFFSET_BITS-1:0] == '0) begin
                    state_next = ST_LOOK_RD;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        tag_we    = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = wdata_reg[{lane, 3'b000} +: 8];
        mem_addr  = {frame_reg, addr_reg[PAGE_OFFSET_BITS-1:0]};
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                mem_addr  = clr_reg;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_LOOK_RD: begin
                tag_we = miss && (act_reg == ACT_WRITE) && !full;
            end
            ST_XFER: begin
                mem_we = (act_reg == ACT_WRITE);
            end
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        act_next       = act_reg;
        addr_next      = addr_reg;
        last_next      = last_reg;
        wdata_next     = wdata_reg;
        idx_next       = idx_reg;
        scan_next      = scan_reg;
        hit_next       = hit_reg;
        frame_next     = frame_reg;
        rdata_next     = rdata_reg;
        status_next    = status_reg;
        used_next      = used_reg;
        clr_next       = clr_reg;
        le_next        = cfg_we ? pwdata[0] : le_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        m_status_next  = m_status_reg;
        pend_next      = (state_reg == ST_XFER) && (act_reg == ACT_READ) && hit_reg;
        pend_lane_next = lane;

        // read byte arrives in the cycle after its address
        if (pend_reg) begin
            rdata_next[{pend_lane_reg, 3'b000} +: 8] = mem_q_reg;
        end

        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + MEM_AW'(1);
            end
            ST_IDLE: begin
                if (accept) begin
                    act_next    = s_action;
                    addr_next   = s_address;
                    last_next   = last_byte_idx(s_size_code);
                    wdata_next  = s_write_data;
                    idx_next    = '0;
                    scan_next   = '0;
                    rdata_next  = '0;
                    status_next = STATUS_OK;
                end
            end
            ST_LOOK_RD: begin
                if (miss) begin
                    if (act_reg == ACT_READ) begin
                        hit_next = 1'b0;
                    end else if (full) begin
                        status_next = STATUS_FULL;
                    end else begin
                        // claim the next free frame
                        hit_next   = 1'b1;
                        frame_next = used_reg[FRAME_W-1:0];
                        used_next  = used_reg + CNT_W'(1);
                    end
                end
            end
            ST_LOOK_CMP: begin
                if (tag_match) begin
                    hit_next   = 1'b1;
                    frame_next = scan_reg[FRAME_W-1:0];
                end else begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end
            ST_XFER: begin
                if (idx_reg != last_reg) begin
                    idx_next  = idx_reg + LANE_W'(1);
                    addr_next = addr_inc;
                    scan_next = '0;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = (act_reg == ACT_WRITE) ? '0 : rdata_reg;
                    m_status_next = status_reg;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            used_reg    <= '0;
            clr_reg     <= '0;
            le_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            clr_reg     <= clr_next;
            le_reg      <= le_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        act_reg       <= act_next;
        addr_reg      <= addr_next;
        last_reg      <= last_next;
        wdata_reg     <= wdata_next;
        idx_reg       <= idx_next;
        scan_reg      <= scan_next;
        hit_reg       <= hit_next;
        frame_reg     <= frame_next;
        rdata_reg     <= rdata_next;
        status_reg    <= status_next;
        pend_lane_reg <= pend_lane_next;
        m_data_reg    <= m_data_next;
        m_status_reg  <= m_status_next;
    end

    // page tag memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (tag_we) begin
            tag_mem[used_reg[FRAME_W-1:0]] <= cur_tag;
        end
        tag_q_reg <= tag_mem[scan_reg[FRAME_W-1:0]];
    end

    // frame byte memory, single port with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[mem_addr] <= mem_wdata;
        end
        mem_q_reg <= frame_mem[mem_addr];
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_data_reg;
    assign m_status    = m_status_reg;

`ifndef NO_ASSERTIONS
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(FRAME_COUNT))
        else $error("frame count beyond frame store");

    a_used_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_CLEAR |=> used_reg >= $past(used_reg))
        else $error("frame count went down");

    a_alloc_room: assert property (@(posedge aclk) disable iff (!aresetn)
        tag_we |-> !full && act_reg == ACT_WRITE)
        else $error("tag written without a free frame");

    a_full_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_read_data == '0)
        else $error("full status with read data");
`endif

endmodule

[tb/tb_sparse_paged_memory.sv]
// ---------------------------------------------------------------------------
// tb_sparse_paged_memory
// self-checking bench for the sparse paged memory: a short table of directed
// requests, then random reads and writes over a small pool of pages, with
// random gaps on both channels, one long result stall and byte order changes
// between phases; every result is compared against a typed table value or a
// behavioral copy of the memory kept inside the bench
// ---------------------------------------------------------------------------
module tb_sparse_paged_memory;
    import spm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // geometry of the block, default parameters
    localparam int PAGE_BITS   = PAGE_OFFSET_BITS_DEF;
    localparam int FRAMES      = FRAME_COUNT_DEF;
    localparam int TAG_W       = ADDR_W - PAGE_BITS;
    localparam int PAGE_BYTES  = 1 << PAGE_BITS;

    // run shape
    localparam int RESET_CYCLES = 6;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 255;
    localparam int POOL_BASES   = 12;
    localparam int POOL_PAGES   = 2 * POOL_BASES;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 200;
    // covers the clearing pass plus ~1550 requests at their longest and the
    // longest gaps on both sides, taken several times over
    localparam int CYCLE_LIMIT  = 1_500_000;

    localparam logic [APB_AW-1:0] LE_REG_ADDR = APB_AW'(4 * int'(CFG_IDX_LITTLE_ENDIAN));

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] size_code;
        logic [DATA_W-1:0] write_data;
    } access_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              status;
    } mem_result_t;

    typedef enum logic {
        ROW_ACCESS,
        ROW_CONFIG
    } row_kind_t;

    // a config row takes the byte order from write_data[0]
    typedef struct packed {
        row_kind_t   kind;
        access_t     req;
        logic        typed;
        mem_result_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 24;

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // big-endian after reset
        '{ROW_CONFIG, '{ACT_READ, 64'h0, 2'd0, 64'h0}, 1'b0, '{64'h0, STATUS_OK}},
        // nothing mapped yet: reads give zero, also across the top of memory
        '{ROW_ACCESS, '{ACT_READ, 64'h0, 2'd3, 64'h0}, 1'b1, '{64'h0, STATUS_OK}},
        '{ROW_ACCESS, '{ACT_READ, 64'hFFFF_FFFF_FFFF_FFFF, 2'd3, 64'h0},
            1'b1, '{64'h0, STATUS_OK}},
        // first write claims a frame for page 0
        '{ROW_ACCESS, '{ACT_WRITE, 64'h0, 2'd3, 64'h0102_0304_0506_0708},
            1'b1, '{64'h0, STATUS_OK}},
        '{ROW_ACCESS, '{ACT_READ, 64'h0, 2'd3, 64'h0},
            1'b1, '{64'h0102_0304_0506_0708, STATUS_OK}},
        '{ROW_ACCESS, '{ACT_READ, 64'h0, 2'd0, 64'h0}, 1'b1, '{64'h01, STATUS_OK}},
        '{ROW_ACCESS, '{ACT_READ, 64'h3, 2'd1, 64'h0}, 1'b1, '{64'h0405, STATUS_OK}},
        '{ROW_ACCESS, '{ACT_READ, 64'h4, 2'd2, 64'h0}, 1'b1, '{64'h0506_0708, STATUS_OK}},
        // unwritten bytes of a claimed frame
        '{ROW_ACCESS, '{ACT_READ, 64'h8, 2'd3, 64'h0}, 1'b1, '{64'h0, STATUS_OK}},
        // write wrapping from the last page into page 0
        '{ROW_ACCESS, '{ACT_WRITE, 64'hFFFF_FFFF_FFFF_FFFC, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF},
            1'b1, '{64'h0, STATUS_OK}},
        '{ROW_ACCESS, '{ACT_READ, 64'hFFFF_FFFF_FFFF_FFFE, 2'd2, 64'h0},
            1'b0, '{64'h0, STATUS_OK}},
        '{ROW_ACCESS, '{ACT_READ, 64'h0, 2'd3, 64'h0}, 1'b0, '{64'h0, STATUS_OK}},
        // page crossing write, two new frames
        '{ROW_ACCESS, '{ACT_WRITE, 64'h1FFE, 2'd2, 64'hDEAD_BEEF_1234_5678},
            1'b0, '{64'h0, STATUS_OK}},
        '{ROW_ACCESS, '{ACT_READ, 64'h1FFC, 2'd3, 64'h0}, 1'b0, '{64'h0, STATUS_OK}},
        '{ROW_ACCESS, '{ACT_WRITE, 64'h3000, 2'd0, 64'h0}, 1'b0, '{64'h0, STATUS_OK}},
        '{ROW_ACCESS, '{ACT_WRITE, 64'h5A5A_5A5A_5A5A_5A5A, 2'd1, 64'hFFFF_FFFF_FFFF_FFFF},
            1'b0, '{64'h0, STATUS_OK}},
        // switch to little-endian
        '{ROW_CONFIG, '{ACT_READ, 64'h0, 2'd0, 64'h1}, 1'b0, '{64'h0, STATUS_OK}},
        '{ROW_ACCESS, '{ACT_READ, 64'h0, 2'd3, 64'h0}, 1'b0, '{64'h0, STATUS_OK}},
        '{ROW_ACCESS, '{ACT_WRITE, 64'h10, 2'd3, 64'h1122_3344_5566_7788},
            1'b1, '{64'h0, STATUS_OK}},
        '{ROW_ACCESS, '{ACT_READ, 64'h10, 2'd0, 64'h0}, 1'b1, '{64'h88, STATUS_OK}},
        '{ROW_ACCESS, '{ACT_READ, 64'h10, 2'd3, 64'h0},
            1'b1, '{64'h1122_3344_5566_7788, STATUS_OK}},
        '{ROW_ACCESS, '{ACT_READ, 64'h1FFE, 2'd2, 64'h0}, 1'b0, '{64'h0, STATUS_OK}},
        // back to big-endian, same bytes read reversed
        '{ROW_CONFIG, '{ACT_READ, 64'h0, 2'd0, 64'h0}, 1'b0, '{64'h0, STATUS_OK}},
        '{ROW_ACCESS, '{ACT_READ, 64'h10, 2'd3, 64'h0},
            1'b1, '{64'h8877_6655_4433_2211, STATUS_OK}}
    };

    // dut signals
    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_action;
    logic [ADDR_W-1:0]   s_address;
    logic [SIZE_W-1:0]   s_size_code;
    logic [DATA_W-1:0]   s_write_data;
    logic                m_valid;
    logic                m_ready;
    logic [DATA_W-1:0]   m_read_data;
    logic                m_status;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // behavioral memory: tags, claimed frame count, bytes, byte order
    bit [TAG_W-1:0]  page_tag_store [FRAMES];
    int unsigned     frames_claimed = 0;
    bit [7:0]        frame_store [FRAMES * PAGE_BYTES];
    logic            little_endian_cfg = 1'b0;

    // results still owed by the block, oldest first
    mem_result_t     access_results_q [$];

    // pages the random requests are drawn from
    logic [TAG_W-1:0] page_pool [POOL_PAGES];

    int unsigned     error_count = 0;
    int unsigned     cycle_count = 0;
    bit              no_gap_mode = 1'b0;
    bit              long_hold_req = 1'b0;

    sparse_paged_memory dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_address    (s_address),
        .s_size_code  (s_size_code),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_status     (m_status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // one request against the behavioral memory; bytes go in address order,
    // each byte looks up the page of its own wrapped address
    function automatic void apply_access(input access_t req, output mem_result_t res);
        int unsigned       nbytes;
        logic [ADDR_W-1:0] byte_addr;
        logic [TAG_W-1:0]  tag;
        int                frame;
        int unsigned       shift;
        bit                stop;
        res.read_data = '0;
        res.status    = STATUS_OK;
        nbytes        = 1 << req.size_code;
        stop          = 1'b0;
        for (int unsigned i = 0; i < nbytes && !stop; i++) begin
            byte_addr = req.address + ADDR_W'(i);
            tag       = byte_addr[ADDR_W-1:PAGE_BITS];
            shift     = little_endian_cfg ? 8 * i : 8 * (nbytes - 1 - i);
            frame     = -1;
            for (int unsigned f = 0; f < frames_claimed; f++) begin
                if (frame < 0 && page_tag_store[f] == tag) begin
                    frame = f;
                end
            end
            if (req.action == ACT_READ) begin
                if (frame >= 0) begin
                    res.read_data |= DATA_W'(frame_store[(frame << PAGE_BITS)
                                     | int'(byte_addr[PAGE_BITS-1:0])]) << shift;
                end
            end else begin
                // unmapped page: claim the next frame, or stop if none is left
                if (frame < 0 && frames_claimed >= FRAMES) begin
                    res.status = STATUS_FULL;
                    stop       = 1'b1;
                end else begin
                    if (frame < 0) begin
                        frame = frames_claimed;
                        page_tag_store[frame] = tag;
                        frames_claimed++;
                    end
                    frame_store[(frame << PAGE_BITS) | int'(byte_addr[PAGE_BITS-1:0])] =
                        req.write_data[shift +: 8];
                end
            end
        end
    endfunction

    // sender gap: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned sel;
        sel = $urandom_range(99);
        if (no_gap_mode || sel < 55) begin
            return 0;
        end
        if (sel < 85) begin
            return $urandom_range(3, 1);
        end
        if (sel < 97) begin
            return $urandom_range(10, 4);
        end
        return $urandom_range(50, 20);
    endfunction

    // offer one request, hold it until taken, then log what must come back
    task automatic offer_access(input access_t req, input logic typed,
                                input mem_result_t typed_res, input int unsigned gap);
        mem_result_t predicted;
        s_valid      <= 1'b1;
        s_action     <= req.action;
        s_address    <= req.address;
        s_size_code  <= req.size_code;
        s_write_data <= req.write_data;
        do @(posedge aclk); while (!s_ready);
        apply_access(req, predicted);
        access_results_q.push_back(typed ? typed_res : predicted);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_results_drained();
        while (access_results_q.size() != 0) @(posedge aclk);
    endtask

    // one apb transfer, setup then access; psel is left high so that
    // transfers can follow back to back
    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                              input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
    endtask

    // write the byte order register, then read it back
    task automatic set_byte_order(input logic le);
        logic [APB_DW-1:0] readback;
        apb_access(1'b1, LE_REG_ADDR, APB_DW'(le), readback);
        little_endian_cfg = le;
        apb_access(1'b0, LE_REG_ADDR, '0, readback);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== APB_DW'(le)) begin
            $display("%0t: little_endian readback mismatch, expected %h, got %h",
                     $time, APB_DW'(le), readback);
            error_count++;
        end
    endtask

    // result side: random ready pattern, plus one long hold when asked for
    initial begin : result_sink
        int unsigned run_left;
        logic        run_ready;
        int unsigned sel;
        run_left  = 0;
        run_ready = 1'b1;
        m_ready  <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                run_ready     = 1'b0;
                run_left      = LONG_HOLD;
            end else if (run_left == 0) begin
                sel = $urandom_range(99);
                if (sel < 60) begin
                    run_ready = 1'b1;
                    run_left  = $urandom_range(16, 1);
                end else if (sel < 75) begin
                    // stretch with no stall at all
                    run_ready = 1'b1;
                    run_left  = $urandom_range(200, 80);
                end else if (sel < 95) begin
                    run_ready = 1'b0;
                    run_left  = $urandom_range(4, 1);
                end else begin
                    run_ready = 1'b0;
                    run_left  = $urandom_range(60, 20);
                end
            end
            run_left--;
            m_ready <= run_ready;
        end
    end

    // result check: every handshake is matched to the oldest expectation
    always @(posedge aclk) begin
        mem_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (access_results_q.size() == 0) begin
                $display("%0t: result with none expected, read_data %h status %b",
                         $time, m_read_data, m_status);
                error_count++;
            end else begin
                want = access_results_q.pop_front();
                if (m_read_data !== want.read_data) begin
                    $display("%0t: read_data mismatch, expected %h, got %h",
                             $time, want.read_data, m_read_data);
                    error_count++;
                end
                if (m_status !== want.status) begin
                    $display("%0t: status mismatch, expected %b, got %b",
                             $time, want.status, m_status);
                    error_count++;
                end
            end
        end
    end

    // hard stop in case the block hangs
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("sparse_paged_memory verification failed");
        $finish;
    end

    initial begin : stimulus
        access_t           req;
        logic [TAG_W-1:0]  base;
        logic [PAGE_BITS-1:0] offset;
        int unsigned       gap;
        int unsigned       sel;

        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_action     <= ACT_READ;
        s_address    <= '0;
        s_size_code  <= '0;
        s_write_data <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table; s_ready stays low through the clearing pass
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_CONFIG) begin
                wait_results_drained();
                set_byte_order(DIRECTED[r].req.write_data[0]);
            end else begin
                gap = pick_gap();
                // valid must drop before a register write or the end
                if ((r + 1 == DIR_ROWS || DIRECTED[r + 1].kind == ROW_CONFIG) && gap == 0) begin
                    gap = 1;
                end
                offer_access(DIRECTED[r].req, DIRECTED[r].typed, DIRECTED[r].want, gap);
            end
        end

        // page pool: pairs of neighboring pages so that crossings hit both
        // mapped and unmapped pages; bottom and top of memory included
        for (int k = 0; k < POOL_BASES; k++) begin
            if (k == 0) begin
                base = '0;
            end else if (k == 1) begin
                base = '1;
            end else begin
                base = TAG_W'({$urandom, $urandom});
            end
            page_pool[2 * k]     = base;
            page_pool[2 * k + 1] = base + 1'b1;
        end

        // random phases, byte order flipped between them; the pool holds
        // more pages than frames, so the memory fills early and full writes
        // (partial ones on crossings too) follow
        for (int p = 0; p < PHASES; p++) begin
            wait_results_drained();
            set_byte_order(p % 2 == 0);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // one phase starts with a long result stall under full load
                no_gap_mode = (p == 2 && i < 60);
                if (p == 2 && i == 0) begin
                    long_hold_req = 1'b1;
                end

                req.action     = ($urandom_range(99) < 50) ? ACT_WRITE : ACT_READ;
                req.size_code  = SIZE_W'($urandom_range(3));
                req.write_data = {$urandom, $urandom};
                sel = $urandom_range(99);
                if (sel < 10) begin
                    // anywhere in memory; writes only once frames are gone
                    req.address = {$urandom, $urandom};
                    if (frames_claimed < FRAMES) begin
                        req.action = ACT_READ;
                    end
                end else begin
                    sel = $urandom_range(99);
                    if (sel < 40) begin
                        offset = PAGE_BITS'($urandom);
                    end else if (sel < 80) begin
                        // close to the end of the page, crossing likely
                        offset = PAGE_BITS'(PAGE_BYTES - 1 - $urandom_range(7));
                    end else begin
                        offset = PAGE_BITS'($urandom_range(7));
                    end
                    req.address = {page_pool[$urandom_range(POOL_PAGES - 1)], offset};
                end

                gap = pick_gap();
                if (i == PHASE_ITEMS - 1 && gap == 0) begin
                    gap = 1;
                end
                offer_access(req, 1'b0, '0, gap);
            end
        end
        no_gap_mode = 1'b0;

        // let the last results come out, then watch for strays
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("sparse_paged_memory verification clean");
        end else begin
            $display("sparse_paged_memory verification failed");
        end
        $finish;
    end

endmodule
